// File: rtl/core/mst_pkg.sv
// Package for the minimum spanning tree block: constants, result kinds, state and edge types.
// No dependencies.
`default_nettype none
package mst_pkg;
  localparam int unsigned MaxNodes = 32;
  localparam int unsigned MaxEdges = 64;
  localparam int unsigned NodeW = 6;
  localparam int unsigned WeightW = 16;
  localparam int unsigned TotalW = 21;
  localparam logic [TotalW-1:0] WeightSat = 21'h1FFFFF;
  localparam logic [NodeW-1:0] NodeCountReset = 6'd32;

  // Result kinds carried on tuser
  localparam logic KindTotal = 1'b0;
  localparam logic KindEdge  = 1'b1;

  typedef enum logic [3:0] {
    ST_LOAD, ST_SORT_RD, ST_SORT_FIRST, ST_SORT_CMP, ST_SORT_WR_I, ST_SORT_WR_B,
    ST_INIT, ST_SCAN_RD, ST_SCAN_CHK, ST_FIND, ST_MERGE,
    ST_OUT_TOTAL, ST_OUT_RD, ST_OUT_EDGE
  } state_e;

  typedef struct packed {
    logic [NodeW-1:0]   lo;
    logic [NodeW-1:0]   hi;
    logic [WeightW-1:0] w;
  } edge_t;
endpackage
`default_nettype wire

// File: rtl/core/min_spanning_tree_kruskal.sv
// Minimum spanning tree block: top level with the edge memory and sequencer.
// Depends on mst_pkg.
//
// Usage: edges arrive on the s_axis channel, one transaction per cycle while
// loading; tdata = {weight, second_node, first_node}, tlast marks the final
// edge and starts the run. Edges beyond MAX_EDGES are dropped and flagged.
// node_count is written on the cfg channel while the block is loading.
// After tlast the block sorts the E stored edges by weight with a selection
// sort, with one memory read per compare and two writes for the swap. The
// scan then reads each edge in turn and, for a candidate edge, follows parent
// hops (at most MAX_NODES) on both endpoints, then merges. A kept edge is
// written back to the memory in kept order. The block then emits the total
// result (tuser = 0) and each kept edge (tuser = 1) in kept order, tlast on
// the final one; each edge result waits for its memory read.
// A stalled receiver holds the output register and the output states of
// the sequencer.
// s_axis_tready is low from tlast until the last result is in the output
// register. Reset returns to loading with an empty store and node_count 32.
`default_nettype none
module min_spanning_tree_kruskal #(
  parameter int unsigned MAX_NODES = mst_pkg::MaxNodes,
  parameter int unsigned MAX_EDGES = mst_pkg::MaxEdges
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // tdata: first_node[5:0], second_node[11:6], weight[27:12], pad
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        s_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: low_node[5:0], high_node[11:6], edge_weight[27:12],
  //        tree_weight[48:28], overflow[49], pad
  output logic [55:0]      m_axis_tdata,
  // tuser: kind
  output logic             m_axis_tuser,
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [5:0]  cfg_data
);
  import mst_pkg::*;

  localparam int unsigned AW = $clog2(MAX_EDGES);
  localparam int unsigned CW = $clog2(MAX_EDGES + 1);
  localparam int unsigned PW = $clog2(MAX_NODES);
  localparam int unsigned GW = $clog2(MAX_NODES + 1);

  state_e state_q, state_d;
  logic [NodeW-1:0] ncfg_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic drop_q, drop_d;
  logic [CW-1:0] i_q, i_d, j_q, j_d, best_q, best_d;
  edge_t ei_q, ei_d, eb_q, eb_d;
  logic [PW-1:0] par_q [MAX_NODES];
  logic par_init, par_we;
  logic [CW-1:0] nkept_q, nkept_d;
  logic [TotalW-1:0] tot_q, tot_d;
  logic [PW-1:0] fa_q, fa_d, fb_q, fb_d;
  logic [GW-1:0] guard_q, guard_d;
  logic [CW-1:0] oi_q, oi_d;
  logic [GW-1:0] n_eff;
  logic ovalid_q, ovalid_d;
  logic [55:0] odata_q, odata_d;
  logic ouser_q, ouser_d;
  logic olast_q, olast_d;

  // Edge memory: registered read, one write port.
  edge_t mem [MAX_EDGES];
  edge_t rd_q;
  logic we;
  logic [AW-1:0] waddr, raddr;
  edge_t wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rd_q <= mem[raddr];
  end

  // Effective node count, clamped to 1..MAX_NODES.
  always_comb begin
    if (ncfg_q == '0) n_eff = GW'(1);
    else if (32'(ncfg_q) > MAX_NODES) n_eff = GW'(MAX_NODES);
    else n_eff = GW'(ncfg_q);
  end

  // Incoming edge with the smaller node first.
  logic [NodeW-1:0] in_a, in_b;
  edge_t in_edge;
  assign in_a = s_axis_tdata[5:0];
  assign in_b = s_axis_tdata[11:6];
  always_comb begin
    in_edge.lo = (in_a < in_b) ? in_a : in_b;
    in_edge.hi = (in_a < in_b) ? in_b : in_a;
    in_edge.w  = s_axis_tdata[27:12];
  end

  assign s_axis_tready = (state_q == ST_LOAD);
  assign cfg_ready = (state_q == ST_LOAD);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata = odata_q;
  assign m_axis_tuser = ouser_q;
  assign m_axis_tlast = olast_q;

  logic out_free;
  assign out_free = !ovalid_q || m_axis_tready;

  logic edge_ok;
  assign edge_ok = rd_q.lo != '0 && 32'(rd_q.hi) <= 32'(n_eff);

  logic [TotalW:0] sum;
  assign sum = {1'b0, tot_q} + (TotalW+1)'(ei_q.w);

  // Sequencer: next state, memory control and output register.
  always_comb begin
    state_d = state_q; cnt_d = cnt_q; drop_d = drop_q;
    i_d = i_q; j_d = j_q; best_d = best_q; ei_d = ei_q; eb_d = eb_q;
    nkept_d = nkept_q; tot_d = tot_q; fa_d = fa_q; fb_d = fb_q;
    guard_d = guard_q; oi_d = oi_q; par_init = 1'b0; par_we = 1'b0;
    ovalid_d = ovalid_q && !m_axis_tready;
    odata_d = odata_q; ouser_d = ouser_q; olast_d = olast_q;
    we = 1'b0; waddr = '0; raddr = '0; wdata = in_edge;
    unique case (state_q)
      ST_LOAD: begin
        waddr = AW'(cnt_q);
        if (s_axis_tvalid) begin
          if (32'(cnt_q) < MAX_EDGES) begin
            we = 1'b1; cnt_d = cnt_q + CW'(1);
          end else drop_d = 1'b1;
          if (s_axis_tlast) begin
            i_d = '0; state_d = ST_SORT_RD;
          end
        end
      end
      // Selection sort: read entry i, then every later entry in turn
      ST_SORT_RD: begin
        if (i_q + CW'(1) >= cnt_q) state_d = ST_INIT;
        else begin
          raddr = AW'(i_q); state_d = ST_SORT_FIRST;
        end
      end
      ST_SORT_FIRST: begin
        ei_d = rd_q; eb_d = rd_q; best_d = i_q; j_d = i_q + CW'(1);
        raddr = AW'(i_q + CW'(1)); state_d = ST_SORT_CMP;
      end
      ST_SORT_CMP: begin
        // keep the first strictly smallest weight
        if (rd_q.w < eb_q.w) begin
          eb_d = rd_q; best_d = j_q;
        end
        if (j_q + CW'(1) < cnt_q) begin
          j_d = j_q + CW'(1); raddr = AW'(j_q + CW'(1));
        end else state_d = ST_SORT_WR_I;
      end
      ST_SORT_WR_I: begin
        we = 1'b1; waddr = AW'(i_q); wdata = eb_q; state_d = ST_SORT_WR_B;
      end
      ST_SORT_WR_B: begin
        we = 1'b1; waddr = AW'(best_q); wdata = ei_q;
        i_d = i_q + CW'(1); state_d = ST_SORT_RD;
      end
      ST_INIT: begin
        par_init = 1'b1; nkept_d = '0; tot_d = '0; i_d = '0;
        state_d = ST_SCAN_RD;
      end
      // Scan the sorted edges until the tree is complete or the edges run out
      ST_SCAN_RD: begin
        if (i_q >= cnt_q || nkept_q == CW'(n_eff) - CW'(1)) state_d = ST_OUT_TOTAL;
        else begin
          raddr = AW'(i_q); state_d = ST_SCAN_CHK;
        end
      end
      ST_SCAN_CHK: begin
        ei_d = rd_q;
        if (!edge_ok) begin
          i_d = i_q + CW'(1); state_d = ST_SCAN_RD;
        end else begin
          fa_d = PW'(rd_q.lo - NodeW'(1)); fb_d = PW'(rd_q.hi - NodeW'(1));
          guard_d = '0; state_d = ST_FIND;
        end
      end
      ST_FIND: begin
        // one parent hop per cycle on each endpoint
        if (32'(guard_q) < MAX_NODES &&
            (par_q[fa_q] != fa_q || par_q[fb_q] != fb_q)) begin
          if (par_q[fa_q] != fa_q) fa_d = par_q[fa_q];
          if (par_q[fb_q] != fb_q) fb_d = par_q[fb_q];
          guard_d = guard_q + GW'(1);
        end else state_d = ST_MERGE;
      end
      ST_MERGE: begin
        // keep the edge if its endpoints lie in different trees: append it to the kept list at the front of memory
        if (fa_q != fb_q) begin
          we = 1'b1; waddr = AW'(nkept_q); wdata = ei_q;
          nkept_d = nkept_q + CW'(1);
          tot_d = sum[TotalW] ? WeightSat : sum[TotalW-1:0];
          par_we = 1'b1;
        end
        i_d = i_q + CW'(1); state_d = ST_SCAN_RD;
      end
      // Emit the total, then the kept edges
      ST_OUT_TOTAL: begin
        if (out_free) begin
          ovalid_d = 1'b1; ouser_d = KindTotal;
          olast_d = (nkept_q == '0);
          odata_d = {6'd0, drop_q, tot_q, 28'd0};
          oi_d = '0;
          if (nkept_q == '0) begin
            state_d = ST_LOAD; cnt_d = '0; drop_d = 1'b0;
          end else state_d = ST_OUT_RD;
        end
      end
      ST_OUT_RD: begin
        raddr = AW'(oi_q); state_d = ST_OUT_EDGE;
      end
      ST_OUT_EDGE: begin
        // hold the read address so rd_q stays put under a stall
        raddr = AW'(oi_q);
        if (out_free) begin
          ovalid_d = 1'b1; ouser_d = KindEdge;
          olast_d = (oi_q + CW'(1) == nkept_q);
          odata_d = {6'd0, drop_q, tot_q, rd_q.w, rd_q.hi, rd_q.lo};
          oi_d = oi_q + CW'(1);
          if (oi_q + CW'(1) == nkept_q) begin
            state_d = ST_LOAD; cnt_d = '0; drop_d = 1'b0;
          end else state_d = ST_OUT_RD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Registers and parent table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD; ncfg_q <= NodeCountReset; cnt_q <= '0; drop_q <= 1'b0;
      i_q <= '0; j_q <= '0; best_q <= '0; ei_q <= '0; eb_q <= '0;
      nkept_q <= '0; tot_q <= '0; fa_q <= '0; fb_q <= '0;
      guard_q <= '0; oi_q <= '0;
      ovalid_q <= 1'b0; odata_q <= '0; ouser_q <= 1'b0; olast_q <= 1'b0;
      for (int k = 0; k < MAX_NODES; k++) par_q[k] <= '0;
    end else begin
      if (cfg_valid && cfg_ready) ncfg_q <= cfg_data;
      state_q <= state_d; cnt_q <= cnt_d; drop_q <= drop_d;
      i_q <= i_d; j_q <= j_d; best_q <= best_d; ei_q <= ei_d; eb_q <= eb_d;
      nkept_q <= nkept_d; tot_q <= tot_d; fa_q <= fa_d; fb_q <= fb_d;
      guard_q <= guard_d; oi_q <= oi_d;
      ovalid_q <= ovalid_d; odata_q <= odata_d; ouser_q <= ouser_d;
      olast_q <= olast_d;
      if (par_init) begin
        for (int k = 0; k < MAX_NODES; k++) par_q[k] <= PW'(k);
      end else if (par_we) begin
        par_q[fb_q] <= fa_q;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> !s_axis_tready) else $error("ready while busy");
  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= MAX_EDGES) else $error("edge count beyond capacity");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("result changed under stall");
`endif
endmodule
`default_nettype wire
